// ----- rtl/byte_string_bucket_hash_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Byte string bucket hash: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_STRING_BUCKET_HASH_UNIT_DEFINES_SVH
`define BYTE_STRING_BUCKET_HASH_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BSBH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BSBH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bsbh_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte string bucket hash: package
// Widths, constants, state and command types shared by the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsbh_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LEN_W      = 8;
	localparam int unsigned HASH_W     = 32;
	localparam int unsigned FACT_W     = 16;
	localparam int unsigned SIZE_W     = 17;
	localparam int unsigned BUCKET_W   = 16;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned CNT_W      = 5;

	localparam logic [LEN_W-1:0]  MAX_KEY_BYTES = 8'd64;
	localparam logic [LEN_W-1:0]  IDX_SAT       = 8'hFF;
	localparam logic [SIZE_W-1:0] SIZE_RESET    = 17'd1024;
	localparam logic [SIZE_W-1:0] SIZE_ONE      = 17'd1;
	localparam logic [SIZE_W-1:0] SIZE_MAX      = 17'd65536;
	localparam logic [CNT_W-1:0]  DIV_LAST      = 5'd31;

	typedef enum logic [1:0] {
		HM_NONE = 2'd0,
		HM_ADD  = 2'd1,
		HM_MUL  = 2'd2
	} hmode_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_FIN  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_LOAD = 5'b10000
	} state_t;

	typedef struct packed {
		logic load_in;
		logic update;
		logic finish;
		logic div_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/byte_string_bucket_hash_unit.sv -----
// ----------------------------------------------------------------------------
// Byte string bucket hash unit
// Hashes a key, one byte per request, into a bucket index and raw hash.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata {key_length, key_byte}, tlast last_byte
//  m_axis    | out       | tdata {raw_hash, bucket}
//  cfg       | in        | data table_size (17 bits)
//
//  Each byte is accepted and its factor formed, then in the update state folded
//  into the hash (an add for bytes 0 and 1, else the 32x16 multiply). A last
//  byte adds the length multiply, the bit-serial modulo and the result load.
//  Reset clears the running hash, the byte index and table_size to 1024.
//  A stalled result holds in the output register while the next key streams in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_string_bucket_hash_unit #(
	parameter logic [bsbh_pkg::LEN_W-1:0] MAX_KEY_BYTES = bsbh_pkg::MAX_KEY_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [bsbh_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // key_byte, key_length
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [bsbh_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // bucket, raw_hash
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bsbh_pkg::SIZE_W-1:0]         cfg_data
);
	import bsbh_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	bsbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bsbh_dp #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule

// ----- rtl/bsbh_dp.sv -----
// ----------------------------------------------------------------------------
// Byte string bucket hash: datapath
// Factor, running hash, final multiply, bit-serial modulo and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsbh_dp #(
	parameter logic [bsbh_pkg::LEN_W-1:0] MAX_KEY_BYTES = bsbh_pkg::MAX_KEY_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bsbh_pkg::cmd_t                      cmd,
	output bsbh_pkg::status_t                   status,
	input  logic [bsbh_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                in_last,
	input  logic                                cfg_valid,
	input  logic [bsbh_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [bsbh_pkg::OUT_DATA_W-1:0]     out_data
);
	import bsbh_pkg::*;

	logic [SIZE_W-1:0]     size_q;
	logic [LEN_W-1:0]      idx_q;
	logic [HASH_W-1:0]     hash_q;
	logic [FACT_W-1:0]     factor_q;
	hmode_t                mode_q;
	logic                  last_q;
	logic [LEN_W-1:0]      len_q;
	logic [HASH_W-1:0]     raw_q;
	logic [HASH_W-1:0]     dvd_q;
	logic [BUCKET_W-1:0]   rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [OUT_DATA_W-1:0] out_q;
	logic                  out_valid_q;

	logic [BYTE_W-1:0]     byte_w;
	logic [LEN_W-1:0]      len_w;
	logic                  active_w;
	logic [FACT_W-1:0]     bi_w;
	logic [FACT_W-1:0]     bl_w;
	logic [FACT_W-1:0]     fac_w;
	hmode_t                mode_w;
	logic [HASH_W-1:0]     mul_w;
	logic [HASH_W-1:0]     fin_w;
	logic [SIZE_W-1:0]     div_w;
	logic [SIZE_W-1:0]     rem_sh_w;

	assign byte_w   = in_data[BYTE_W-1:0];
	assign len_w    = in_data[IN_DATA_W-1:BYTE_W];
	assign active_w = (idx_q < len_w) && (idx_q < MAX_KEY_BYTES);
	assign bi_w     = {8'h00, byte_w} * {8'h00, idx_q};
	assign bl_w     = {8'h00, byte_w} * {8'h00, len_w};

	always_comb begin
		mode_w = HM_NONE;
		fac_w  = bi_w + {8'h00, len_w} + {8'h00, idx_q};
		if (active_w) begin
			if (idx_q == 8'd0) begin
				mode_w = HM_ADD;
				fac_w  = {8'h00, byte_w};
			end else if (idx_q == 8'd1) begin
				mode_w = HM_ADD;
				fac_w  = bl_w;
			end else begin
				mode_w = HM_MUL;
			end
		end
	end

	assign mul_w = hash_q * {16'h0000, factor_q};
	assign fin_w = hash_q * {24'h000000, len_q};

	always_comb begin
		priority if (size_q == '0) begin
			div_w = SIZE_ONE;
		end else if (size_q > SIZE_MAX) begin
			div_w = SIZE_MAX;
		end else begin
			div_w = size_q;
		end
	end

	assign rem_sh_w = {rem_q, dvd_q[HASH_W-1]};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	// key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hash_q <= '0;
		end else begin
			if (cmd.load_in) begin
				if (in_last) begin
					idx_q <= '0;
				end else if (idx_q != IDX_SAT) begin
					idx_q <= idx_q + 8'd1;
				end
			end
			if (cmd.update) begin
				unique case (mode_q)
					HM_ADD:  hash_q <= hash_q + {16'h0000, factor_q};
					HM_MUL:  hash_q <= mul_w;
					default: hash_q <= hash_q;
				endcase
			end else if (cmd.finish) begin
				hash_q <= '0;
			end
		end
	end

	// request payload and division registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			factor_q <= fac_w;
			mode_q   <= mode_w;
			last_q   <= in_last;
			len_q    <= len_w;
		end
		if (cmd.finish) begin
			raw_q <= fin_w;
			dvd_q <= fin_w;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
			if (rem_sh_w >= div_w) begin
				rem_q <= BUCKET_W'(rem_sh_w - div_w);
			end else begin
				rem_q <= rem_sh_w[BUCKET_W-1:0];
			end
		end
		if (cmd.emit) begin
			out_q <= {raw_q, rem_q};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.last     = last_q;
	assign status.div_last = (cnt_q == DIV_LAST);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/bsbh_ctrl.sv -----
// ----------------------------------------------------------------------------
// Byte string bucket hash: controller
// Sequences accept, hash update, final multiply, modulo and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsbh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsbh_pkg::status_t   status,
	output bsbh_pkg::cmd_t      cmd
);
	import bsbh_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = status.last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				// hold until the result register frees
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/bsbh_checker.sv -----
// ----------------------------------------------------------------------------
// Byte string bucket hash: port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_string_bucket_hash_unit_defines.svh"

module bsbh_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                s_axis_tlast,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [bsbh_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	// stalled result holds
	`BSBH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// every request occupies the hash update the next cycle
	`BSBH_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken during hash update")

	// a last byte keeps input closed after the final multiply, once the modulo is under way
	`BSBH_ASSERT_NOW(a_busy_modulo, s_axis_tvalid && s_axis_tready && s_axis_tlast, ##3 !s_axis_tready, "request taken during modulo")

	// a fresh result is loaded only on the way back to idle
	`BSBH_ASSERT_NOW(a_load_idle, $rose(m_axis_tvalid), s_axis_tready, "result loaded outside idle")

endmodule

bind byte_string_bucket_hash_unit bsbh_checker u_bsbh_checker (.*);
